### src/i2d_pkg.sv
// ============================================================================
// i2d_pkg - shared definitions for the integer to decimal text converter
// Character codes, digit counts and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package i2d_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned LEFT_W   = $clog2(DIGITS + 1);
    localparam int unsigned ITER_W   = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture a new value and form its magnitude
        logic dabble;       // one shift and add-three step
        logic shift_digit;  // drop the top BCD digit
        logic push_sign;    // load a minus sign into the output register
        logic push_digit;   // load the top BCD digit into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic top_zero;     // the top BCD digit is zero
        logic left_one;     // only one digit remains to be sent
        logic negative;     // the captured value was negative
        logic out_free;     // the output register can take a character
    } t_status;

endpackage

### src/i2d_datapath.sv
// ============================================================================
// i2d_datapath - binary to BCD converter and output register
// Holds the magnitude, the BCD digits and the output register, and acts on
// the commands of the controller.
// ============================================================================
module i2d_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  i2d_pkg::t_cmd                       i_cmd,
    output i2d_pkg::t_status                    o_status,
    input  logic signed [i2d_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [i2d_pkg::CHAR_W-1:0]          o_char,
    output logic                                o_last
);
    import i2d_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd_adj;
    logic [LEFT_W-1:0]  r_left;
    logic               r_neg;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic [VALUE_W-1:0] n_mag;

    assign n_mag = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // Add three to every digit of five or more ahead of the shift.
    always_comb begin
        logic [3:0] v_dig;
        for (int d = 0; d < DIGITS; d++) begin
            v_dig = r_bcd[4*d +: 4];
            n_bcd_adj[4*d +: 4] = (v_dig >= 4'd5) ? v_dig + 4'd3 : v_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= n_mag;
            r_bcd  <= '0;
            r_left <= LEFT_W'(DIGITS);
            r_neg  <= i_value[VALUE_W-1];
        end else if (i_cmd.dabble) begin
            r_bcd <= {n_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_cmd.shift_digit) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.push_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.push_digit) begin
            r_out_char <= CHAR_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]};
            r_out_last <= (r_left == LEFT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_sign || i_cmd.push_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign o_status.left_one = (r_left == LEFT_W'(1));
    assign o_status.negative = r_neg;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

### src/i2d_ctrl.sv
// ============================================================================
// i2d_ctrl - sequencing controller
// Steps through capture, conversion, leading zero removal and the sending
// of the sign and the digits.
// ============================================================================
module i2d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  i2d_pkg::t_status  i_status,
    output i2d_pkg::t_cmd     o_cmd
);
    import i2d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGITS
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] n_iter;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_iter  = r_iter;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_iter     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                n_iter       = r_iter + 1'b1;
                if (r_iter == ITER_W'(VALUE_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.top_zero && !i_status.left_one) begin
                    o_cmd.shift_digit = 1'b1;
                end else begin
                    n_state = i_status.negative ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.push_sign = 1'b1;
                    n_state         = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (i_status.out_free) begin
                    o_cmd.push_digit  = 1'b1;
                    o_cmd.shift_digit = 1'b1;
                    if (i_status.left_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### src/int_to_decimal_text.sv
// ============================================================================
// int_to_decimal_text - signed 32-bit integer to decimal ASCII characters
// The first character comes later for shorter texts, as more leading zeros
// are dropped first; one character then follows per cycle while the output
// is taken. A new value is accepted once the last digit of the previous one
// has entered the output register. The pace is set by the 32-step shift and
// add-three loop, the minus sign when one is sent, and the ten digit slots,
// each dropped as a leading zero or sent through the single output register,
// one a cycle while the output is taken. Synchronous active-low reset
// empties the output register and returns the controller to idle.
// ============================================================================
module int_to_decimal_text (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream. tdata fields from bit 0: value[31:0] (signed).
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic signed [i2d_pkg::VALUE_W-1:0]  i_s_tdata,
    // Output stream. tdata fields from bit 0: text_char[7:0].
    // tlast carries last_char, high on the final character of a value.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [i2d_pkg::CHAR_W-1:0]          o_m_tdata,
    output logic                                o_m_tlast
);
    import i2d_pkg::*;

    // The controller and the datapath exchange only these two bundles.
    t_cmd    w_cmd;
    t_status w_status;

    // The controller accepts a transfer only when idle. The value is
    // captured, its magnitude converted to ten BCD digits by the shift and
    // add-three loop, and leading zeros dropped one digit a cycle (keeping at
    // least one, so that zero gives '0'); finally the sign and digits are sent.
    i2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath owns the output register, so a finished character can
    // wait for the downstream side while a new value is already accepted.
    i2d_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_value  (i_s_tdata),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_char   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule

### src/i2d_checker.sv
// ============================================================================
// i2d_checker - port level checks for the decimal text converter
// Watches the stream ports of the top level and flags behaviour that the
// converter must never show.
// ============================================================================
module i2d_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               i_s_tready,
    input logic                               i_m_tvalid,
    input logic                               i_m_tready,
    input logic [i2d_pkg::CHAR_W-1:0]         i_m_tdata,
    input logic                               i_m_tlast
);
    import i2d_pkg::*;

    // The converter does not accept a value straight after taking one.
    a_busy_after_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted again straight after a transfer");

    // Only a minus sign or a decimal digit is ever sent.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata == CHAR_MINUS ||
                        (i_m_tdata >= CHAR_ZERO && i_m_tdata <= CHAR_ZERO + 8'd9)))
        else $error("character outside the sign and digit set");

    // A sign never ends a value's text.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata == CHAR_MINUS) |-> !i_m_tlast)
        else $error("minus sign marked as the last character");

    // A stalled character is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast)))
        else $error("output changed while stalled");

endmodule

bind int_to_decimal_text i2d_checker u_i2d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

### dv/tb.sv
// ============================================================================
// tb - self-checking testbench for int_to_decimal_text
// Sends signed 32-bit values and checks the character stream against a local
// model of the decimal text. The run covers directed extremes, random values
// spread over every digit count, and a long stall on the output side.
// ============================================================================
module tb;

    import i2d_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned PRINT_CAP    = 50;

    // One character of the expected text, with its end-of-value flag.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic signed [VALUE_W-1:0]  i_s_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [CHAR_W-1:0]          o_m_tdata;
    logic                       o_m_tlast;

    t_text_char  expected_text[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned sink_hold_cycles;
    bit          source_idles;
    bit          sink_idles;

    int_to_decimal_text dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    // Queues the decimal text of one value: an optional minus sign, then
    // the digits of the magnitude, most significant first.
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[10];
        int                 ndig;
        t_text_char         tc;
        // The magnitude is unsigned, so the most negative value fits.
        mag  = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % 32'd10);
            mag          = mag / 32'd10;
            ndig++;
        end while (mag != 0);
        if (raw[VALUE_W-1]) begin
            tc.code = CHAR_MINUS;
            tc.last = 1'b0;
            expected_text.push_back(tc);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            tc.code = CHAR_ZERO + CHAR_W'(digits[k]);
            tc.last = (k == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Picks a value whose magnitude has a random digit count, so short and
    // long texts both turn up often; now and then any 32-bit pattern.
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        bit          negative;
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        ndig     = $urandom_range(1, 10);
        negative = $urandom_range(0, 1);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        if (ndig == 1) lo = 0;
        hi = (ndig == 10) ? (negative ? 32'h8000_0000 : 32'h7fff_ffff)
                          : (lo == 0 ? 9 : lo * 10 - 1);
        mag = $urandom_range(hi, lo);
        return negative ? (~mag + 1) : mag;
    endfunction

    // Offers one value and waits for its transfer. It is entered and left
    // at a falling edge; tvalid stays high into the next call when no gap
    // is drawn, so it is never lowered and raised in one time step.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int unsigned gap;
        gap = source_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= v;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        queue_decimal_text(v);
        @(negedge i_clk);
    endtask

    // Sink side: a random gap before each character, or one long hold-off
    // when a test asks for it, counted here in cycles.
    initial begin : sink_ready
        int unsigned gap;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (sink_hold_cycles > 0) begin
                gap              = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                gap = sink_idles ? $urandom_range(0, 5) : 0;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            @(negedge i_clk);
        end
    end

    // Each character transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_text.size() == 0) begin
                flag_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                        o_m_tdata, o_m_tlast));
            end else begin
                want = expected_text.pop_front();
                if (o_m_tdata !== want.code) begin
                    flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            o_m_tdata, want.code));
                end
                if (o_m_tlast !== want.last) begin
                    flag_mismatch($sformatf("last flag %0b, expected %0b",
                                            o_m_tlast, want.last));
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Zero, single digits, the ten-digit extremes and the most negative
    // value, whose magnitude only fits as an unsigned quantity.
    task automatic test_directed_extremes();
        logic [VALUE_W-1:0] values[$];
        values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                   32'd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
                   32'd123456789, -32'sd987654321, 32'h7fff_ffff,
                   32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
                   32'h0f0f_0f0f, 32'hf0f0_f0f0};
        foreach (values[i]) send_value(values[i]);
    endtask

    // Random values in blocks, switching idling on either side so that
    // some stretches run with no gaps at all.
    task automatic test_random_values(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                source_idles = ($urandom_range(0, 3) != 0);
                sink_idles   = ($urandom_range(0, 3) != 0);
            end
            send_value(random_value());
        end
        source_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    // The sink holds off for a long stretch while values keep coming, so
    // the block fills and must stall its input.
    task automatic test_output_backpressure();
        source_idles     = 1'b0;
        sink_hold_cycles = 600;
        for (int i = 0; i < 20; i++) send_value(random_value());
        source_idles = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_s_tvalid       = 1'b0;
        i_s_tdata        = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        source_idles     = 1'b1;
        sink_idles       = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_output_backpressure();
        test_random_values(440);

        i_s_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            flag_mismatch($sformatf("%0d characters never arrived",
                                    expected_text.size()));
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
